### rtl/srlm_pkg.sv
// shared constants for the sector ring log manager: action codes and field widths
// no dependencies; imported by the controller, the entry ram and the top level
package srlm_pkg;

    localparam int ACTION_W = 3;
    localparam int WORD_W   = 32;
    localparam int ENTRY_W  = 2 * WORD_W;
    localparam int CFG_W    = 4;

    localparam logic [WORD_W-1:0] ERASED_WORD = 32'hFFFF_FFFF;

    localparam logic [ACTION_W-1:0] ACT_FORMAT     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_MOUNT      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE      = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ_START = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ_NEXT  = 3'd4;

endpackage

### rtl/srlm_ram.sv
// entry store: one write port and one registered read port
// depends on srlm_pkg for the entry width
module srlm_ram
    import srlm_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [ENTRY_W-1:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output logic [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/srlm_ctrl.sv
// sequencer for the log: pointers, erase sweeps, mount scan, tail search, result register
// depends on srlm_pkg; drives the ports of srlm_ram
module srlm_ctrl
    import srlm_pkg::*;
#(
    parameter int MAX_SECTORS  = 8,
    parameter int SECTOR_SLOTS = 16,
    parameter int DEPTH        = MAX_SECTORS * SECTOR_SLOTS,
    parameter int AW           = $clog2(DEPTH),
    parameter int SECW         = $clog2(MAX_SECTORS + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SECW-1:0]     ring_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    input  logic [WORD_W-1:0]   entry_id,
    input  logic [WORD_W-1:0]   entry_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                ok,
    output logic [WORD_W-1:0]   read_id,
    output logic [WORD_W-1:0]   read_data,
    output logic                at_end,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output logic [ENTRY_W-1:0]  mem_wdata,
    output logic                mem_re,
    output logic [AW-1:0]       mem_raddr,
    input  logic [ENTRY_W-1:0]  mem_rdata
);

    localparam int SLW  = $clog2(SECTOR_SLOTS);
    localparam int RUNW = $clog2(SECTOR_SLOTS + 1);
    localparam logic [SLW-1:0]  LAST_SLOT = SLW'(SECTOR_SLOTS - 1);
    localparam logic [SECW-1:0] LAST_SEC  = SECW'(MAX_SECTORS - 1);
    localparam logic [RUNW-1:0] FULL_RUN  = RUNW'(SECTOR_SLOTS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERASE,
        ST_FDONE,
        ST_WEXEC,
        ST_WSTORE,
        ST_RSTART,
        ST_RNEXT,
        ST_NOP,
        ST_MSTART,
        ST_MBASE,
        ST_MLAST,
        ST_MRUN,
        ST_MEND,
        ST_TSTART,
        ST_TCHK
    } state_t;

    function automatic logic [AW-1:0] addr_of(input logic [SECW-1:0] s,
                                              input logic [SLW-1:0] t);
        addr_of = AW'(int'(s) * SECTOR_SLOTS + int'(t));
    endfunction

    function automatic logic [SECW-1:0] sec_inc(input logic [SECW-1:0] s,
                                                input logic [SECW-1:0] n);
        logic [SECW-1:0] t;
        t = s + SECW'(1);
        sec_inc = (t >= n) ? '0 : t;
    endfunction

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic [WORD_W-1:0] id_reg, id_next;
    logic [WORD_W-1:0] data_reg, data_next;

    logic [SECW-1:0] hd_sec_reg, hd_sec_next;
    logic [SLW-1:0]  hd_slot_reg, hd_slot_next;
    logic [SECW-1:0] lt_sec_reg, lt_sec_next;
    logic [SLW-1:0]  lt_slot_reg, lt_slot_next;
    logic [SECW-1:0] tl_sec_reg, tl_sec_next;
    logic [SECW-1:0] rd_sec_reg, rd_sec_next;
    logic [SLW-1:0]  rd_slot_reg, rd_slot_next;
    logic            first_reg, first_next;

    logic [SECW-1:0] er_sec_reg, er_sec_next;
    logic [SLW-1:0]  er_slot_reg, er_slot_next;
    logic [SECW-1:0] er_last_reg, er_last_next;

    logic [SECW-1:0] sc_sec_reg, sc_sec_next;
    logic [SECW-1:0] fe_reg, fe_next;
    logic            empty_reg, empty_next;
    logic [RUNW-1:0] run_reg, run_next;
    logic [SECW-1:0] step_reg, step_next;
    logic [SECW-1:0] hs_reg, hs_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg, out_ok_next;
    logic [WORD_W-1:0] out_id_reg, out_id_next;
    logic [WORD_W-1:0] out_data_reg, out_data_next;
    logic              out_end_reg, out_end_next;

    logic              go;
    logic              finish;
    logic              res_ok;
    logic [WORD_W-1:0] res_id;
    logic [WORD_W-1:0] res_data;
    logic              used;
    logic [SECW-1:0]   pos_sec;
    logic [SLW-1:0]    pos_slot;
    logic [SECW-1:0]   nxt_sec;
    logic [RUNW-1:0]   run_fin;
    logic              do_store;
    logic [SECW-1:0]   st_sec;
    logic [SLW-1:0]    st_slot;
    logic [SECW-1:0]   rn_sec;
    logic [SLW-1:0]    rn_slot;
    logic              rd_allowed;

    assign go       = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign used     = (mem_rdata[ENTRY_W-1 -: WORD_W] != ERASED_WORD);

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        id_next      = id_reg;
        data_next    = data_reg;
        hd_sec_next  = hd_sec_reg;
        hd_slot_next = hd_slot_reg;
        lt_sec_next  = lt_sec_reg;
        lt_slot_next = lt_slot_reg;
        tl_sec_next  = tl_sec_reg;
        rd_sec_next  = rd_sec_reg;
        rd_slot_next = rd_slot_reg;
        first_next   = first_reg;
        er_sec_next  = er_sec_reg;
        er_slot_next = er_slot_reg;
        er_last_next = er_last_reg;
        sc_sec_next  = sc_sec_reg;
        fe_next      = fe_reg;
        empty_next   = empty_reg;
        run_next     = run_reg;
        step_next    = step_reg;
        hs_next      = hs_reg;

        mem_we    = 1'b0;
        mem_waddr = addr_of(er_sec_reg, er_slot_reg);
        mem_wdata = {ENTRY_W{1'b1}};
        mem_re    = 1'b0;
        mem_raddr = addr_of(rd_sec_reg, rd_slot_reg);

        finish   = 1'b0;
        res_ok   = 1'b0;
        res_id   = '0;
        res_data = '0;

        // a head at or past the ring end wraps to the start
        pos_sec  = (hd_sec_reg >= ring_n) ? '0 : hd_sec_reg;
        pos_slot = (hd_sec_reg >= ring_n) ? '0 : hd_slot_reg;
        nxt_sec  = sec_inc(pos_sec, ring_n);
        run_fin  = used ? FULL_RUN : run_reg;
        do_store = 1'b0;
        st_sec   = pos_sec;
        st_slot  = pos_slot;

        rn_sec  = (rd_slot_reg == LAST_SLOT) ? rd_sec_reg + SECW'(1) : rd_sec_reg;
        rn_slot = (rd_slot_reg == LAST_SLOT) ? '0 : rd_slot_reg + SLW'(1);
        if (rn_sec >= ring_n)
        begin
            rn_sec  = '0;
            rn_slot = '0;
        end
        rd_allowed = !((rd_sec_reg == tl_sec_reg) && (rd_slot_reg == '0)) || first_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // prefetch the read position so read_next has its entry next cycle
                mem_re = 1'b1;
                if (in_valid)
                begin
                    id_next   = entry_id;
                    data_next = entry_data;
                    case (action)
                        ACT_FORMAT:
                        begin
                            er_sec_next  = '0;
                            er_slot_next = '0;
                            er_last_next = ring_n - SECW'(1);
                            ret_next     = ST_FDONE;
                            state_next   = ST_ERASE;
                        end
                        ACT_MOUNT:      state_next = ST_MSTART;
                        ACT_WRITE:      state_next = ST_WEXEC;
                        ACT_READ_START: state_next = ST_RSTART;
                        ACT_READ_NEXT:  state_next = ST_RNEXT;
                        default:        state_next = ST_NOP;
                    endcase
                end
            end

            ST_ERASE:
            begin
                mem_we = 1'b1;
                if (er_slot_reg == LAST_SLOT)
                begin
                    er_slot_next = '0;
                    if (er_sec_reg == er_last_reg)
                    begin
                        state_next = ret_reg;
                    end
                    else
                    begin
                        er_sec_next = er_sec_reg + SECW'(1);
                    end
                end
                else
                begin
                    er_slot_next = er_slot_reg + SLW'(1);
                end
            end

            ST_FDONE:
            begin
                if (go)
                begin
                    hd_sec_next  = '0;
                    hd_slot_next = '0;
                    lt_sec_next  = '0;
                    lt_slot_next = '0;
                    tl_sec_next  = '0;
                    rd_sec_next  = '0;
                    rd_slot_next = '0;
                    first_next   = 1'b1;
                    res_ok       = 1'b1;
                    finish       = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            ST_WEXEC:
            begin
                if (pos_slot == LAST_SLOT)
                begin
                    // last slot of a sector: erase the following sector first
                    er_sec_next  = nxt_sec;
                    er_last_next = nxt_sec;
                    er_slot_next = '0;
                    if (nxt_sec == tl_sec_reg)
                    begin
                        tl_sec_next = sec_inc(tl_sec_reg, ring_n);
                    end
                    if (ring_n == SECW'(1))
                    begin
                        hd_sec_next  = '0;
                        hd_slot_next = '0;
                    end
                    else
                    begin
                        hd_sec_next  = pos_sec;
                        hd_slot_next = pos_slot;
                    end
                    ret_next   = ST_WSTORE;
                    state_next = ST_ERASE;
                end
                else
                begin
                    do_store = 1'b1;
                end
            end

            ST_WSTORE:
            begin
                do_store = 1'b1;
                st_sec   = hd_sec_reg;
                st_slot  = hd_slot_reg;
            end

            ST_RSTART:
            begin
                if (go)
                begin
                    rd_sec_next  = tl_sec_reg;
                    rd_slot_next = '0;
                    first_next   = 1'b1;
                    res_ok       = 1'b1;
                    finish       = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            ST_RNEXT:
            begin
                if (go)
                begin
                    if (rd_allowed && used)
                    begin
                        res_ok       = 1'b1;
                        res_id       = mem_rdata[ENTRY_W-1 -: WORD_W];
                        res_data     = mem_rdata[WORD_W-1:0];
                        first_next   = 1'b0;
                        rd_sec_next  = rn_sec;
                        rd_slot_next = rn_slot;
                    end
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_NOP:
            begin
                if (go)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_MSTART:
            begin
                mem_re      = 1'b1;
                mem_raddr   = addr_of('0, '0);
                sc_sec_next = '0;
                fe_next     = ring_n;
                empty_next  = 1'b1;
                run_next    = '0;
                state_next  = (ring_n == SECW'(1)) ? ST_MRUN : ST_MBASE;
            end

            ST_MBASE:
            begin
                if (used)
                begin
                    empty_next = 1'b0;
                    mem_re     = 1'b1;
                    mem_raddr  = addr_of(sc_sec_reg, LAST_SLOT);
                    state_next = ST_MLAST;
                end
                else
                begin
                    if (fe_reg == ring_n)
                    begin
                        fe_next = sc_sec_reg;
                    end
                    if (sc_sec_reg == ring_n - SECW'(1))
                    begin
                        state_next = ST_MEND;
                    end
                    else
                    begin
                        sc_sec_next = sc_sec_reg + SECW'(1);
                        mem_re      = 1'b1;
                        mem_raddr   = addr_of(sc_sec_reg + SECW'(1), '0);
                    end
                end
            end

            ST_MLAST:
            begin
                if (!used)
                begin
                    // partly filled sector: count its used run from slot 0
                    run_next   = '0;
                    mem_re     = 1'b1;
                    mem_raddr  = addr_of(sc_sec_reg, '0);
                    state_next = ST_MRUN;
                end
                else if (sc_sec_reg == ring_n - SECW'(1))
                begin
                    state_next = ST_MEND;
                end
                else
                begin
                    sc_sec_next = sc_sec_reg + SECW'(1);
                    mem_re      = 1'b1;
                    mem_raddr   = addr_of(sc_sec_reg + SECW'(1), '0);
                    state_next  = ST_MBASE;
                end
            end

            ST_MRUN:
            begin
                if (used && (run_reg != FULL_RUN - RUNW'(1)))
                begin
                    run_next  = run_reg + RUNW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = addr_of(sc_sec_reg, SLW'(run_reg + RUNW'(1)));
                end
                else if (ring_n == SECW'(1))
                begin
                    if (go)
                    begin
                        tl_sec_next = '0;
                        if (run_fin == '0)
                        begin
                            hd_sec_next  = '0;
                            hd_slot_next = '0;
                            lt_sec_next  = '0;
                            lt_slot_next = '0;
                        end
                        else
                        begin
                            lt_sec_next  = '0;
                            lt_slot_next = SLW'(run_fin - RUNW'(1));
                            if (run_fin == FULL_RUN)
                            begin
                                hd_sec_next  = SECW'(1);
                                hd_slot_next = '0;
                            end
                            else
                            begin
                                hd_sec_next  = '0;
                                hd_slot_next = SLW'(run_fin);
                            end
                        end
                        res_ok     = 1'b1;
                        finish     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    lt_sec_next  = sc_sec_reg;
                    lt_slot_next = SLW'(run_fin - RUNW'(1));
                    hd_sec_next  = sc_sec_reg;
                    hd_slot_next = SLW'(run_fin);
                    state_next   = ST_TSTART;
                end
            end

            ST_MEND:
            begin
                if (empty_reg)
                begin
                    if (go)
                    begin
                        hd_sec_next  = '0;
                        hd_slot_next = '0;
                        lt_sec_next  = '0;
                        lt_slot_next = '0;
                        tl_sec_next  = '0;
                        res_ok       = 1'b1;
                        finish       = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    // every used sector is full: latest sits at the start of the one before
                    if ((fe_reg == '0) || (fe_reg == ring_n))
                    begin
                        lt_sec_next = ring_n - SECW'(1);
                    end
                    else
                    begin
                        lt_sec_next = fe_reg - SECW'(1);
                    end
                    lt_slot_next = '0;
                    hd_sec_next  = fe_reg;
                    hd_slot_next = '0;
                    state_next   = ST_TSTART;
                end
            end

            ST_TSTART:
            begin
                hs_next     = pos_sec;
                sc_sec_next = nxt_sec;
                step_next   = SECW'(1);
                mem_re      = 1'b1;
                mem_raddr   = addr_of(nxt_sec, '0);
                state_next  = ST_TCHK;
            end

            ST_TCHK:
            begin
                if (used || (step_reg == ring_n - SECW'(1)))
                begin
                    if (go)
                    begin
                        tl_sec_next = used ? sc_sec_reg : hs_reg;
                        res_ok      = 1'b1;
                        finish      = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
                else
                begin
                    step_next   = step_reg + SECW'(1);
                    sc_sec_next = sec_inc(sc_sec_reg, ring_n);
                    mem_re      = 1'b1;
                    mem_raddr   = addr_of(sec_inc(sc_sec_reg, ring_n), '0);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_store && go)
        begin
            mem_we       = 1'b1;
            mem_waddr    = addr_of(st_sec, st_slot);
            mem_wdata    = {id_reg, data_reg};
            lt_sec_next  = st_sec;
            lt_slot_next = st_slot;
            if (st_slot == LAST_SLOT)
            begin
                hd_sec_next  = st_sec + SECW'(1);
                hd_slot_next = '0;
            end
            else
            begin
                hd_sec_next  = st_sec;
                hd_slot_next = st_slot + SLW'(1);
            end
            res_ok     = 1'b1;
            finish     = 1'b1;
            state_next = ST_IDLE;
        end

        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_id_next    = out_id_reg;
        out_data_next  = out_data_reg;
        out_end_next   = out_end_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
            out_ok_next    = res_ok;
            out_id_next    = res_id;
            out_data_next  = res_data;
            out_end_next   = (rd_sec_next == lt_sec_next) && (rd_slot_next == lt_slot_next);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // reset starts with a clearing pass over the whole store
            state_reg     <= ST_ERASE;
            ret_reg       <= ST_IDLE;
            id_reg        <= '0;
            data_reg      <= '0;
            hd_sec_reg    <= '0;
            hd_slot_reg   <= '0;
            lt_sec_reg    <= '0;
            lt_slot_reg   <= '0;
            tl_sec_reg    <= '0;
            rd_sec_reg    <= '0;
            rd_slot_reg   <= '0;
            first_reg     <= 1'b1;
            er_sec_reg    <= '0;
            er_slot_reg   <= '0;
            er_last_reg   <= LAST_SEC;
            sc_sec_reg    <= '0;
            fe_reg        <= '0;
            empty_reg     <= 1'b1;
            run_reg       <= '0;
            step_reg      <= '0;
            hs_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_id_reg    <= '0;
            out_data_reg  <= '0;
            out_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            id_reg        <= id_next;
            data_reg      <= data_next;
            hd_sec_reg    <= hd_sec_next;
            hd_slot_reg   <= hd_slot_next;
            lt_sec_reg    <= lt_sec_next;
            lt_slot_reg   <= lt_slot_next;
            tl_sec_reg    <= tl_sec_next;
            rd_sec_reg    <= rd_sec_next;
            rd_slot_reg   <= rd_slot_next;
            first_reg     <= first_next;
            er_sec_reg    <= er_sec_next;
            er_slot_reg   <= er_slot_next;
            er_last_reg   <= er_last_next;
            sc_sec_reg    <= sc_sec_next;
            fe_reg        <= fe_next;
            empty_reg     <= empty_next;
            run_reg       <= run_next;
            step_reg      <= step_next;
            hs_reg        <= hs_next;
            out_valid_reg <= out_valid_next;
            out_ok_reg    <= out_ok_next;
            out_id_reg    <= out_id_next;
            out_data_reg  <= out_data_next;
            out_end_reg   <= out_end_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = out_ok_reg;
    assign read_id   = out_id_reg;
    assign read_data = out_data_reg;
    assign at_end    = out_end_reg;

`ifndef ASSERT_OFF
    a_slots_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (hd_slot_reg <= LAST_SLOT) && (lt_slot_reg <= LAST_SLOT) && (rd_slot_reg <= LAST_SLOT))
        else $error("pointer slot beyond sector size");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("store written while idle");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is in progress");

    a_erase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ERASE) |-> (er_sec_reg <= er_last_reg))
        else $error("erase sweep ran past its last sector");

    a_quiet_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> ((out_id_reg == '0) && (out_data_reg == '0)))
        else $error("failed result carries entry data");
`endif

endmodule

### rtl/sector_ring_log_manager.sv
// top level of the sector ring log manager: ring size register, controller, entry store
// depends on srlm_pkg, srlm_ctrl and srlm_ram
//
// A circular log of 64-bit entries held in MAX_SECTORS sectors of SECTOR_SLOTS
// entries, all in one ram with a single read port. Items are taken one at a time;
// in_ready is high only while the controller is idle, even when a result still waits
// in the output register. A write to the last slot of a sector also sweeps the next
// sector first. format sweeps the n sectors in use. mount reads sector starts and
// ends one ram read per cycle, then at most SECTOR_SLOTS reads to count a partial
// sector and n - 1 reads to find the tail. After reset a clearing pass sets every
// entry to all ones, with in_ready low; the user is to write the sectors_used
// register only at idle time, which the block itself does not enforce.
module sector_ring_log_manager
    import srlm_pkg::*;
#(
    parameter int MAX_SECTORS  = 8,
    parameter int SECTOR_SLOTS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sectors_used_we,
    input  logic [CFG_W-1:0]    sectors_used,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    input  logic [WORD_W-1:0]   entry_id,
    input  logic [WORD_W-1:0]   entry_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                ok,
    output logic [WORD_W-1:0]   read_id,
    output logic [WORD_W-1:0]   read_data,
    output logic                at_end
);

    localparam int DEPTH = MAX_SECTORS * SECTOR_SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SECW  = $clog2(MAX_SECTORS + 1);
    localparam int UW    = (SECW > CFG_W) ? SECW : CFG_W;

    logic [UW-1:0]      sectors_used_reg;
    logic [SECW-1:0]    ring_n;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sectors_used_reg <= UW'(MAX_SECTORS);
        end
        else if (sectors_used_we)
        begin
            sectors_used_reg <= UW'(sectors_used);
        end
    end

    // zero acts as one sector, anything above the built size as the built size
    always_comb
    begin
        if (sectors_used_reg == '0)
        begin
            ring_n = SECW'(1);
        end
        else if (sectors_used_reg > UW'(MAX_SECTORS))
        begin
            ring_n = SECW'(MAX_SECTORS);
        end
        else
        begin
            ring_n = SECW'(sectors_used_reg);
        end
    end

    srlm_ctrl #(
        .MAX_SECTORS  (MAX_SECTORS),
        .SECTOR_SLOTS (SECTOR_SLOTS),
        .DEPTH        (DEPTH),
        .AW           (AW),
        .SECW         (SECW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .ring_n     (ring_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .entry_id   (entry_id),
        .entry_data (entry_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ok         (ok),
        .read_id    (read_id),
        .read_data  (read_data),
        .at_end     (at_end),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    srlm_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
